### rtl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

    localparam int PAT_SLOTS   = 16;
    localparam int PAT_BITS    = 8 * PAT_SLOTS;
    localparam int LEN_W       = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PAT_LO = 3'd0;
    localparam t_cfg_idx CFG_PAT_HI = 3'd1;
    localparam t_cfg_idx CFG_CARE   = 3'd2;
    localparam t_cfg_idx CFG_LEN    = 3'd3;
    localparam t_cfg_idx CFG_LIMIT  = 3'd4;
    localparam t_cfg_idx CFG_BASE   = 3'd5;

    // pattern seen by every cell, length already clamped
    typedef struct packed {
        logic [PAT_BITS-1:0]  bytes;
        logic [PAT_SLOTS-1:0] care;
        logic [LEN_W-1:0]     len;
    } t_pat;

    // per-cell shift control
    typedef struct packed {
        logic shift;
        logic flush;
    } t_cell_ctl;

endpackage

`default_nettype wire

### rtl/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell
// One window cell: holds the byte received K requests ago and compares it
// with the pattern byte that lines up with it at the current length.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_cell
    import mbps_pkg::*;
#(
    parameter int K = 0
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_pat      i_pat,
    input  wire logic [7:0] i_byte,
    input  wire logic      i_valid,
    output logic [7:0]     o_byte,
    output logic           o_valid,
    output logic           o_hit
);

    logic [7:0]       r_byte;
    logic             r_valid;
    logic [LEN_W-1:0] w_idx_full;
    logic [3:0]       w_idx;
    logic             w_in_use;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_ctl.flush ? 1'b0 : i_valid;
        end
    end

    // pattern byte len-1-K sits at this cell
    always_comb begin
        w_in_use   = LEN_W'(K) < i_pat.len;
        w_idx_full = i_pat.len - LEN_W'(K + 1);
        w_idx      = w_idx_full[3:0];
        o_hit      = !w_in_use || !i_pat.care[w_idx] ||
                     (r_byte == i_pat.bytes[w_idx*8 +: 8]);
    end

    assign o_byte  = r_byte;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

### rtl/masked_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Scans a byte stream for a masked pattern through a chain of window cells.
// A byte waits in the pending stage; results are registered when output frees.
// Throughput: one byte per cycle unless stalled; cells shift on accepted bytes.
// Stall from the output reaches the input only through the one pending stage.
// Reset: synchronous active low; clears config, window, position and counts.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_scanner
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int ADDRESS_WIDTH     = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // byte input
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_region_end,
    // results
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_match_found,
    output logic [31:0]                o_match_address,
    output logic                       o_region_done,
    output logic [15:0]                o_match_count
);

    localparam int AW_CUT = (ADDRESS_WIDTH < 32) ? ADDRESS_WIDTH : 32;
    localparam logic [31:0] ADDR_MASK = 32'((64'(1) << AW_CUT) - 64'(1));
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN_BYTES);

    // configuration registers
    logic [63:0]      r_pat_lo;
    logic [63:0]      r_pat_hi;
    logic [15:0]      r_care;
    logic [LEN_W-1:0] r_len;
    logic [15:0]      r_limit;
    logic [31:0]      r_base;

    // pending stage
    logic             r_pend;
    logic             r_last;
    logic [31:0]      r_pos;
    logic [31:0]      r_offset;
    logic [31:0]      n_pos;

    // region counters
    logic [15:0]      r_cnt;
    logic             r_lim_hit;
    logic [15:0]      n_cnt;
    logic             n_lim_hit;

    logic             w_accept;
    logic             w_adv;
    logic             w_full;
    logic             w_hit;
    logic             w_emit;
    logic [31:0]      w_addr;
    t_pat             w_pat;
    t_cell_ctl        w_ctl [MAX_PATTERN_BYTES];

    logic [7:0]                   w_cell_byte  [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] w_cell_valid;
    logic [MAX_PATTERN_BYTES-1:0] w_cell_hit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_care   <= '0;
            r_len    <= LEN_W'(1);
            r_limit  <= '0;
            r_base   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PAT_LO: r_pat_lo <= i_cfg_data;
                CFG_PAT_HI: r_pat_hi <= i_cfg_data;
                CFG_CARE:   r_care   <= i_cfg_data[15:0];
                CFG_LEN:    r_len    <= i_cfg_data[LEN_W-1:0];
                CFG_LIMIT:  r_limit  <= i_cfg_data[15:0];
                CFG_BASE:   r_base   <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_pat.bytes = {r_pat_hi, r_pat_lo};
        w_pat.care  = r_care;
        if (r_len == '0) begin
            w_pat.len = LEN_W'(1);
        end else if (r_len > LEN_MAX) begin
            w_pat.len = LEN_MAX;
        end else begin
            w_pat.len = r_len;
        end
    end

    // handshake: evaluate pending byte when the output slot frees up
    assign w_adv    = r_pend && (!o_valid || !i_stall);
    assign o_stall  = r_pend && !w_adv;
    assign w_accept = i_valid && !o_stall;

    // window chain; after a region's last byte the older cells are flushed
    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
            assign w_ctl[k].shift = w_accept;
            assign w_ctl[k].flush = (k != 0) && r_last;
            if (k == 0) begin : g_head
                mbps_cell #(.K(k)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctl   (w_ctl[k]),
                    .i_pat   (w_pat),
                    .i_byte  (i_data_byte),
                    .i_valid (1'b1),
                    .o_byte  (w_cell_byte[k]),
                    .o_valid (w_cell_valid[k]),
                    .o_hit   (w_cell_hit[k])
                );
            end else begin : g_body
                mbps_cell #(.K(k)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctl   (w_ctl[k]),
                    .i_pat   (w_pat),
                    .i_byte  (w_cell_byte[k-1]),
                    .i_valid (w_cell_valid[k-1]),
                    .o_byte  (w_cell_byte[k]),
                    .o_valid (w_cell_valid[k]),
                    .o_hit   (w_cell_hit[k])
                );
            end
        end
    endgenerate

    assign n_pos = (r_last ? 32'd0 : r_pos) + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_last <= 1'b0;
            r_pos  <= '0;
        end else if (w_accept) begin
            r_pend <= 1'b1;
            r_last <= i_region_end;
            r_pos  <= n_pos;
        end else if (w_adv) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_offset <= n_pos - 32'(w_pat.len);
        end
    end

    // window complete when the cell at age len-1 holds a byte
    always_comb begin
        w_full = 1'b0;
        for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
            if (LEN_W'(j + 1) == w_pat.len) begin
                w_full = w_cell_valid[j];
            end
        end
    end

    always_comb begin
        w_hit     = w_full && !r_lim_hit && (&w_cell_hit);
        n_cnt     = (w_hit && r_cnt != 16'hFFFF) ? r_cnt + 16'd1 : r_cnt;
        n_lim_hit = r_lim_hit || (w_hit && r_limit != '0 && n_cnt >= r_limit);
        w_emit    = w_hit || r_last;
        w_addr    = (r_base + r_offset) & ADDR_MASK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_lim_hit <= 1'b0;
        end else if (w_adv) begin
            r_cnt     <= r_last ? 16'd0 : n_cnt;
            r_lim_hit <= r_last ? 1'b0 : n_lim_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= w_emit;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            o_match_found   <= w_hit;
            o_match_address <= w_hit ? w_addr : 32'd0;
            o_region_done   <= r_last;
            o_match_count   <= n_cnt;
        end
    end

    // a result without a match must close a region
    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_match_found || o_region_done))
        else $error("result with neither match nor region end");

    a_match_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_match_found) |-> (o_match_count != 16'd0))
        else $error("match reported with zero count");

    a_stall_only_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_pend && o_valid && i_stall))
        else $error("input stalled without a blocked pending byte");

    a_region_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_last) |=> (r_cnt == 16'd0 && !r_lim_hit))
        else $error("region counters not cleared after last byte");

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the masked byte pattern scanner. A queue-fed driver
// sends bytes in random bursts while the results side stalls on its own
// pattern. A predictor tracks the window, position, count and limit and
// queues the expected results. A monitor compares each result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mbps_pkg::*;

    localparam t_cfg_idx   CFG_SPARE_A   = 3'd6;
    localparam t_cfg_idx   CFG_SPARE_B   = 3'd7;
    localparam logic [7:0] ASCII_QMARK   = 8'h3F;
    localparam int         DRAIN_CYCLES  = 8;
    localparam int         LONG_HOLD     = 200;
    localparam int         RANDOM_ITEMS  = 1500;
    localparam int         MAX_REPORTS   = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } scan_byte_t;

    typedef struct packed {
        logic        found;
        logic [31:0] addr;
        logic        done;
        logic [15:0] count;
    } scan_result_t;

    typedef struct packed {
        t_cfg_idx    idx;
        logic [63:0] value;
    } reg_write_t;

    typedef enum int {RX_FLOW, RX_SPARSE, RX_PERIODIC, RX_HEAVY} rx_mode_t;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  i_valid      = 1'b0;
    logic [7:0]            i_data_byte  = '0;
    logic                  i_region_end = 1'b0;
    logic                  i_stall      = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_stall;
    logic                  o_valid;
    logic                  o_match_found;
    logic [31:0]           o_match_address;
    logic                  o_region_done;
    logic [15:0]           o_match_count;

    masked_byte_pattern_scanner i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_region_end    (i_region_end),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_match_found   (o_match_found),
        .o_match_address (o_match_address),
        .o_region_done   (o_region_done),
        .o_match_count   (o_match_count)
    );

    always #5 i_clk = ~i_clk;

    scan_byte_t   bytes_to_send [$];
    scan_result_t results_due   [$];
    int           mismatch_count = 0;
    bit           long_hold_arm  = 1'b0;

    // register copies
    logic [63:0] pat_lo_cfg = '0;
    logic [63:0] pat_hi_cfg = '0;
    logic [15:0] care_cfg   = '0;
    logic [4:0]  len_cfg    = 5'd1;
    logic [15:0] limit_cfg  = '0;
    logic [31:0] base_cfg   = '0;

    // per-region scan state
    logic [7:0]  win [PAT_SLOTS];
    logic [31:0] pos;
    logic [15:0] seen;
    logic        limit_hit;
    int          fill;

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic clear_region_state();
        for (int k = 0; k < PAT_SLOTS; k++)
            win[k] = '0;
        pos       = '0;
        seen      = '0;
        limit_hit = 1'b0;
        fill      = 0;
    endtask

    function automatic int eff_len();
        if (len_cfg == 0)
            return 1;
        if (len_cfg > PAT_SLOTS)
            return PAT_SLOTS;
        return int'(len_cfg);
    endfunction

    function automatic logic [7:0] pattern_at(int j);
        logic [PAT_BITS-1:0] all_bytes;
        all_bytes = {pat_hi_cfg, pat_lo_cfg};
        return all_bytes[8*j +: 8];
    endfunction

    function automatic reg_write_t cfg_entry(t_cfg_idx idx, logic [63:0] value);
        reg_write_t e;
        e.idx   = idx;
        e.value = value;
        return e;
    endfunction

    task automatic mirror_write(t_cfg_idx idx, logic [63:0] value);
        case (idx)
            CFG_PAT_LO: pat_lo_cfg = value;
            CFG_PAT_HI: pat_hi_cfg = value;
            CFG_CARE:   care_cfg   = value[15:0];
            CFG_LEN:    len_cfg    = value[4:0];
            CFG_LIMIT:  limit_cfg  = value[15:0];
            CFG_BASE:   base_cfg   = value[31:0];
            default:    ;
        endcase
    endtask

    // shift one byte in, test the window ending here, queue what comes out
    task automatic scan_step(logic [7:0] data, logic last);
        int           n;
        logic         hit;
        logic         ok;
        logic [31:0]  addr;
        scan_result_t r;
        n    = eff_len();
        hit  = 1'b0;
        addr = '0;
        for (int k = PAT_SLOTS - 1; k > 0; k--)
            win[k] = win[k-1];
        win[0] = data;
        pos = pos + 32'd1;
        if (fill < PAT_SLOTS)
            fill++;
        if (fill >= n && !limit_hit) begin
            ok = 1'b1;
            for (int j = 0; j < n; j++)
                if (care_cfg[j] && win[n-1-j] != pattern_at(j))
                    ok = 1'b0;
            if (ok) begin
                hit  = 1'b1;
                addr = base_cfg + (pos - 32'(n));
                if (seen != 16'hFFFF)
                    seen++;
                if (limit_cfg != 0 && seen >= limit_cfg)
                    limit_hit = 1'b1;
            end
        end
        if (hit || last) begin
            r.found = hit;
            r.addr  = addr;
            r.done  = last;
            r.count = seen;
            results_due = {results_due, r};
        end
        if (last)
            clear_region_state();
    endtask

    // sender: bursts of requests with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        scan_byte_t nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                scan_step(i_data_byte, i_region_end);
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (bytes_to_send.size() > 0) begin
                    nxt = bytes_to_send.pop_front();
                    i_valid      <= 1'b1;
                    i_data_byte  <= nxt.data;
                    i_region_end <= nxt.last;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall modes of random length, plus one long hold on request
    rx_mode_t rx_mode   = RX_FLOW;
    int       mode_left = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int       rx_cycle  = 0;

    always @(posedge i_clk) begin
        logic stall_nxt;
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            stall_nxt = 1'b1;
        end else if (long_hold_arm && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            stall_nxt = 1'b1;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 120);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_FLOW:     stall_nxt = 1'b0;
                RX_SPARSE:   stall_nxt = ($urandom_range(0, 3) == 0);
                RX_PERIODIC: stall_nxt = ((rx_cycle % 7) < 3);
                default:     stall_nxt = ($urandom_range(0, 3) != 0);
            endcase
        end
        i_stall <= stall_nxt;
    end

    always @(posedge i_clk) begin
        scan_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result found=%0b addr=%h done=%0b count=%0d",
                    o_match_found, o_match_address, o_region_done, o_match_count));
            end else begin
                want = results_due.pop_front();
                if (o_match_found !== want.found || o_match_address !== want.addr ||
                    o_region_done !== want.done || o_match_count !== want.count)
                    report_mismatch($sformatf(
                        "got found=%0b addr=%h done=%0b count=%0d, want %0b %h %0b %0d",
                        o_match_found, o_match_address, o_region_done, o_match_count,
                        want.found, want.addr, want.done, want.count));
            end
        end
    end

    task automatic add_byte(logic [7:0] data, logic last);
        scan_byte_t b;
        b.data = data;
        b.last = last;
        bytes_to_send = {bytes_to_send, b};
    endtask

    // waits on the falling edge so queue and valid are settled, ends on a rising edge
    task automatic wait_drained();
        do @(negedge i_clk);
        while (bytes_to_send.size() != 0 || i_valid || results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_writes(reg_write_t writes[$]);
        foreach (writes[i]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= writes[i].idx;
            i_cfg_data  <= writes[i].value;
            do @(posedge i_clk);
            while (!o_cfg_ready);
            mirror_write(writes[i].idx, writes[i].value);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // unused upper bits of a register write get random junk half the time
    function automatic logic [63:0] junk_above(int width, logic [63:0] field);
        logic [63:0] keep;
        keep = (64'd1 << width) - 64'd1;
        if ($urandom_range(0, 1) == 0)
            return field;
        return ({$urandom, $urandom} & ~keep) | (field & keep);
    endfunction

    task automatic random_config();
        reg_write_t  w [$];
        logic [4:0]  len_pick;
        logic [15:0] care_pick;
        logic [15:0] limit_pick;
        logic [31:0] base_pick;
        case ($urandom_range(0, 9))
            0:       len_pick = 5'd0;
            1:       len_pick = 5'd16;
            2:       len_pick = 5'($urandom_range(17, 31));
            default: len_pick = 5'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 5))
            0:       care_pick = 16'h0000;
            1:       care_pick = 16'hFFFF;
            default: care_pick = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: limit_pick = 16'($urandom_range(1, 4));
            3:       limit_pick = 16'hFFFF;
            4:       limit_pick = 16'($urandom);
            default: limit_pick = 16'h0000;
        endcase
        case ($urandom_range(0, 4))
            0:       base_pick = 32'h0000_0000;
            1:       base_pick = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
            default: base_pick = $urandom;
        endcase
        w = {w, cfg_entry(CFG_PAT_LO, {$urandom, $urandom})};
        w = {w, cfg_entry(CFG_PAT_HI, {$urandom, $urandom})};
        w = {w, cfg_entry(CFG_CARE,   junk_above(16, 64'(care_pick)))};
        w = {w, cfg_entry(CFG_LEN,    junk_above(5, 64'(len_pick)))};
        w = {w, cfg_entry(CFG_LIMIT,  junk_above(16, 64'(limit_pick)))};
        w = {w, cfg_entry(CFG_BASE,   junk_above(32, 64'(base_pick)))};
        if ($urandom_range(0, 5) == 0)
            w = {w, cfg_entry(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B,
                              {$urandom, $urandom})};
        apply_writes(w);
    endtask

    // noise with pattern copies planted in it; care bytes match, the rest random
    task automatic build_region(int rlen, bit terminate);
        logic [7:0] region_bytes [$];
        int         n;
        int         start;
        n = eff_len();
        for (int i = 0; i < rlen; i++)
            region_bytes = {region_bytes, (($urandom_range(0, 2) == 0) ?
                pattern_at($urandom_range(0, n - 1)) : 8'($urandom))};
        if (rlen >= n) begin
            repeat ($urandom_range(0, 3)) begin
                start = $urandom_range(0, rlen - n);
                for (int j = 0; j < n; j++)
                    region_bytes[start + j] = care_cfg[j] ? pattern_at(j) : 8'($urandom);
            end
        end
        for (int i = 0; i < rlen; i++)
            add_byte(region_bytes[i], terminate && i == rlen - 1);
    endtask

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        reg_write_t w [$];
        int         random_sent;
        int         target;
        int         placed;
        int         rlen;
        logic [7:0] seq [$];

        clear_region_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: length one, no care bits, so every byte hits
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h80, 1'b1);
        wait_drained();

        // "A?C" with the middle byte a wildcard, limit of two matches
        w = {};
        w = {w, cfg_entry(CFG_PAT_LO, {40'hFF_FFFF_FFFF, "C", ASCII_QMARK, "A"})};
        w = {w, cfg_entry(CFG_PAT_HI, 64'hFFFF_FFFF_FFFF_FFFF)};
        w = {w, cfg_entry(CFG_CARE,   64'hFFFF_FFFF_FFFF_FFFD)};
        w = {w, cfg_entry(CFG_LEN,    64'hFFFF_FFFF_FFFF_FFE3)};
        w = {w, cfg_entry(CFG_LIMIT,  64'h5A5A_A5A5_1234_0002)};
        w = {w, cfg_entry(CFG_BASE,   64'hFFFF_FFFF_0000_1000)};
        apply_writes(w);
        seq = {"A", "x", "C", "A", ASCII_QMARK, "B", "A", ASCII_QMARK, "C",
               "A", "Q", "C", "Q"};
        foreach (seq[i])
            add_byte(seq[i], i == seq.size() - 1);
        wait_drained();

        // length zero acts as one; base at the top so the address wraps
        w = {};
        w = {w, cfg_entry(CFG_PAT_LO,  64'h0000_0000_0000_00FF)};
        w = {w, cfg_entry(CFG_CARE,    64'h0000_0000_0000_0001)};
        w = {w, cfg_entry(CFG_LEN,     64'h0000_0000_0000_0000)};
        w = {w, cfg_entry(CFG_LIMIT,   64'h0000_0000_0000_0000)};
        w = {w, cfg_entry(CFG_BASE,    64'h0000_0000_FFFF_FFFF)};
        w = {w, cfg_entry(CFG_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF)};
        w = {w, cfg_entry(CFG_SPARE_B, 64'h0123_4567_89AB_CDEF)};
        apply_writes(w);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);
        wait_drained();

        // every byte from the second on hits; the receiver holds off meanwhile
        w = {};
        w = {w, cfg_entry(CFG_CARE, 64'h0000_0000_0000_0000)};
        w = {w, cfg_entry(CFG_LEN,  64'h0000_0000_0000_0002)};
        w = {w, cfg_entry(CFG_BASE, 64'(32'($urandom)))};
        apply_writes(w);
        for (int i = 0; i < 150; i++)
            add_byte(8'($urandom), i == 149);
        long_hold_arm = 1'b1;
        wait_drained();

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            random_config();
            target = $urandom_range(60, 220);
            placed = 0;
            while (placed < target) begin
                case ($urandom_range(0, 7))
                    0:       rlen = 1;
                    1:       rlen = eff_len();
                    default: rlen = $urandom_range(1, 40);
                endcase
                // now and then a region runs on into the next settings
                build_region(rlen, !(placed + rlen >= target && $urandom_range(0, 3) == 0));
                placed += rlen;
            end
            random_sent += placed;
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
